// ----- design/dfsd_pkg.sv -----
// Shared types and constants of the delta frame stream decoder.
package dfsd_pkg;

    localparam int ADDR_W    = 16;
    localparam int CNT_W     = 15;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;

    localparam logic [15:0] DICT_BIAS = 16'h2000;

    typedef enum logic [2:0] {
        PH_LOW,
        PH_HIGH,
        PH_LITERAL,
        PH_DICT_LOW,
        PH_DICT_HIGH,
        PH_BANK_SKIP
    } t_phase;

    typedef enum logic [1:0] {
        SEL_BANK_SKIP,
        SEL_END_FRAME,
        SEL_RESERVED,
        SEL_END_ANIM
    } t_ctl_sel;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_COPY,
        CMD_READ
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ST_TAKEN     = 3'd0,
        ST_END_FRAME = 3'd1,
        ST_END_ANIM  = 3'd2,
        ST_RESERVED  = 3'd3,
        ST_READ_DONE = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_COPY_RD,
        BK_COPY_WR
    } t_back_state;

    typedef struct packed {
        t_cmd_kind          kind;
        t_status            status;
        logic [7:0]         data;
        logic [ADDR_W-1:0]  dst;
        logic [ADDR_W-1:0]  src;
        logic [CNT_W-1:0]   count;
        logic [ADDR_W-1:0]  cursor;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    function automatic logic [CNT_W-1:0] run_length(input logic [15:0] word);
        return {1'b0, word[14:1]} + 15'd1;
    endfunction

endpackage

// ----- design/dfsd_in_if.sv -----
// Input channel of the decoder: stream bytes and buffer reads.
interface dfsd_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  stream_byte;
    logic [14:0] read_address;

    modport source (output valid, output opcode, output stream_byte, output read_address,
                    input ready);
    modport sink (input valid, input opcode, input stream_byte, input read_address,
                  output ready);
endinterface

// ----- design/dfsd_out_if.sv -----
// Output channel of the decoder: one result per input transaction.
interface dfsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic [14:0] cursor_position;

    modport source (output valid, output status, output read_data, output cursor_position,
                    input ready);
    modport sink (input valid, input status, input read_data, input cursor_position,
                  output ready);
endinterface

// ----- design/delta_frame_stream_decoder_top.sv -----
// Top level of the delta frame stream decoder.
//
// Each input transaction either feeds one byte of the compressed stream or
// reads one byte of the frame buffer, and yields exactly one output
// transaction with a status, the read byte and the write cursor.
// The stream start offset is loaded by a single write on the configuration
// port; write it only while the block is idle.
// After reset the frame buffer is cleared one byte per cycle; input ready
// stays low until that pass ends.
// FRAME_BYTES must be a power of two.
// The front end takes one transaction per cycle into a four-entry queue when not full.
// The back end retires a command byte or literal from its idle state, a read
// through its read state and a dictionary copy through a read and a write
// state per copied byte, due to its single buffer read port and registered read data.
// Each result waits in the queue, is taken by the back end and is then held in
// the output register; a read or dictionary copy first runs its back-end states.
// When the receiver stalls, the result holds in the output register, the
// queue fills and input ready then falls until space returns.
module delta_frame_stream_decoder_top #(
    parameter int FRAME_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    dfsd_in_if.sink     i_in_chan,
    dfsd_out_if.source  o_out_chan
);
    import dfsd_pkg::*;

    logic     push;
    logic     pop;
    logic     clear_done;
    t_cmd     push_entry;
    t_cmd     head;
    t_q_flags q_flags;

    dfsd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_clear_done  (clear_done),
        .i_q_flags     (q_flags),
        .i_chan        (i_in_chan),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    dfsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_flags (q_flags)
    );

    dfsd_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_q_flags    (q_flags),
        .o_pop        (pop),
        .o_clear_done (clear_done),
        .o_chan       (o_out_chan)
    );

    a_no_result_while_clearing : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !clear_done |-> !o_out_chan.valid
    ) else $error("Result presented during the buffer clearing pass.");

    a_clear_stays_done : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        clear_done |=> clear_done
    ) else $error("Buffer clearing pass restarted without reset.");

    a_accept_reaches_queue : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_chan.valid && i_in_chan.ready) |=> !q_flags.empty
    ) else $error("Accepted transaction did not reach the operation queue.");

endmodule

// ----- design/dfsd_front.sv -----
// Front end: accepts transactions, parses the command stream and issues buffer operations.
module dfsd_front #(
    parameter int FRAME_BYTES = 32768
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [15:0]     i_cfg_wr_data,
    input  logic            i_clear_done,
    input  dfsd_pkg::t_q_flags i_q_flags,
    dfsd_in_if.sink         i_chan,
    output logic            o_push,
    output dfsd_pkg::t_cmd  o_entry
);
    import dfsd_pkg::*;

    localparam logic [16:0] ADDR_MASK = 17'(FRAME_BYTES - 1);
    localparam logic [15:0] MASK16    = ADDR_MASK[15:0];

    t_phase            r_phase, n_phase;
    logic [15:0]       r_cmd_word, n_cmd_word;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [7:0]        r_dict_lo, n_dict_lo;
    logic [15:0]       r_pos, n_pos;
    logic [15:0]       r_cursor, n_cursor;

    logic              accept;
    logic [15:0]       word;
    logic [CNT_W-1:0]  len_hi;
    logic [CNT_W-1:0]  len_cw;
    logic [15:0]       pos_inc;
    logic [16:0]       sum_hi, sum_cw, sum_one;
    logic [15:0]       dict_raw;
    t_cmd              cmd;

    assign i_chan.ready = i_clear_done & ~i_q_flags.full;
    assign accept       = i_chan.valid & i_chan.ready;

    assign word     = {i_chan.stream_byte, r_cmd_word[7:0]};
    assign len_hi   = run_length(word);
    assign len_cw   = run_length(r_cmd_word);
    assign pos_inc  = r_pos + 16'd1;
    assign sum_hi   = (17'(r_cursor) + 17'(len_hi)) & ADDR_MASK;
    assign sum_cw   = (17'(r_cursor) + 17'(len_cw)) & ADDR_MASK;
    assign sum_one  = (17'(r_cursor) + 17'd1) & ADDR_MASK;
    assign dict_raw = {i_chan.stream_byte, r_dict_lo} - DICT_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LOW;
            r_cmd_word <= '0;
            r_run      <= '0;
            r_dict_lo  <= '0;
            r_pos      <= '0;
            r_cursor   <= '0;
        end else begin
            r_phase    <= n_phase;
            r_cmd_word <= n_cmd_word;
            r_run      <= n_run;
            r_dict_lo  <= n_dict_lo;
            r_pos      <= n_pos;
            r_cursor   <= n_cursor;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_cmd_word = r_cmd_word;
        n_run      = r_run;
        n_dict_lo  = r_dict_lo;
        n_pos      = r_pos;
        n_cursor   = r_cursor;
        cmd        = '0;
        cmd.kind   = CMD_NONE;
        cmd.status = ST_TAKEN;
        if (accept) begin
            if (i_chan.opcode) begin
                cmd.kind   = CMD_READ;
                cmd.status = ST_READ_DONE;
                cmd.src    = 16'(i_chan.read_address) & MASK16;
            end else begin
                n_pos = pos_inc;
                unique case (r_phase)
                    PH_LOW: begin
                        n_cmd_word = {8'h00, i_chan.stream_byte};
                        n_phase    = PH_HIGH;
                    end
                    PH_HIGH: begin
                        n_cmd_word = word;
                        if (word[15]) begin
                            if (word[0]) begin
                                n_cursor = sum_hi[15:0];
                                n_phase  = PH_LOW;
                            end else begin
                                n_phase = PH_DICT_LOW;
                            end
                        end else if (word[0]) begin
                            n_run   = len_hi;
                            n_phase = PH_LITERAL;
                        end else begin
                            unique case (t_ctl_sel'(word[2:1]))
                                SEL_BANK_SKIP: begin
                                    if (r_pos == 16'd0) begin
                                        n_cmd_word = {8'h00, i_chan.stream_byte};
                                        n_phase    = PH_HIGH;
                                    end else if (pos_inc == 16'd0) begin
                                        n_phase = PH_LOW;
                                    end else begin
                                        n_phase = PH_BANK_SKIP;
                                    end
                                end
                                SEL_END_FRAME: begin
                                    n_cursor   = '0;
                                    n_phase    = PH_LOW;
                                    cmd.status = ST_END_FRAME;
                                end
                                SEL_END_ANIM: begin
                                    n_cursor   = '0;
                                    n_phase    = PH_LOW;
                                    cmd.status = ST_END_ANIM;
                                end
                                SEL_RESERVED: begin
                                    n_cursor   = '0;
                                    n_phase    = PH_LOW;
                                    cmd.status = ST_RESERVED;
                                end
                            endcase
                        end
                    end
                    PH_LITERAL: begin
                        cmd.kind = CMD_WRITE;
                        cmd.data = i_chan.stream_byte;
                        cmd.dst  = r_cursor;
                        n_cursor = sum_one[15:0];
                        if (r_run != '0) begin
                            n_run = r_run - 15'd1;
                        end
                        if (r_run <= 15'd1) begin
                            n_phase = PH_LOW;
                        end
                    end
                    PH_DICT_LOW: begin
                        n_dict_lo = i_chan.stream_byte;
                        n_phase   = PH_DICT_HIGH;
                    end
                    PH_DICT_HIGH: begin
                        cmd.kind  = CMD_COPY;
                        cmd.dst   = r_cursor;
                        cmd.src   = dict_raw & MASK16;
                        cmd.count = len_cw;
                        n_cursor  = sum_cw[15:0];
                        n_phase   = PH_LOW;
                    end
                    PH_BANK_SKIP: begin
                        if (pos_inc == 16'd0) begin
                            n_phase = PH_LOW;
                        end
                    end
                    default: begin
                        n_phase = PH_LOW;
                    end
                endcase
            end
        end
        if (i_cfg_wr_en) begin
            n_pos = i_cfg_wr_data;
        end
        cmd.cursor = n_cursor;
    end

    assign o_push  = accept;
    assign o_entry = cmd;

endmodule

// ----- design/dfsd_queue.sv -----
// Short queue of buffer operations between the front end and the back end.
module dfsd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dfsd_pkg::t_cmd     i_entry,
    input  logic               i_pop,
    output dfsd_pkg::t_cmd     o_head,
    output dfsd_pkg::t_q_flags o_flags
);
    import dfsd_pkg::*;

    t_cmd                r_slots [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_PTR_W:0]    r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_entry;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_head        = r_slots[r_rd_ptr];
    assign o_flags.full  = (r_count == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

// ----- design/dfsd_back.sv -----
// Back end: owns the frame buffer, runs buffer operations and registers the results.
module dfsd_back #(
    parameter int FRAME_BYTES = 32768
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dfsd_pkg::t_cmd i_head,
    input  dfsd_pkg::t_q_flags i_q_flags,
    output logic           o_pop,
    output logic           o_clear_done,
    dfsd_out_if.source     o_chan
);
    import dfsd_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);

    logic [7:0]        r_mem [FRAME_BYTES];
    logic [7:0]        r_rdata;

    t_back_state       r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [AW-1:0]     r_src, n_src;
    logic [AW-1:0]     r_dst, n_dst;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_status           r_hold_status, n_hold_status;
    logic [14:0]       r_hold_cursor, n_hold_cursor;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [7:0]        r_out_data, n_out_data;
    logic [14:0]       r_out_cursor, n_out_cursor;

    logic              out_free;
    logic              load;
    t_status           load_status;
    logic [7:0]        load_data;
    logic [14:0]       load_cursor;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [7:0]        mem_wdata;
    logic [AW-1:0]     mem_raddr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
        r_src         <= n_src;
        r_dst         <= n_dst;
        r_cnt         <= n_cnt;
        r_hold_status <= n_hold_status;
        r_hold_cursor <= n_hold_cursor;
        r_out_status  <= n_out_status;
        r_out_data    <= n_out_data;
        r_out_cursor  <= n_out_cursor;
    end

    assign out_free = ~r_out_valid | o_chan.ready;

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_src         = r_src;
        n_dst         = r_dst;
        n_cnt         = r_cnt;
        n_hold_status = r_hold_status;
        n_hold_cursor = r_hold_cursor;
        o_pop         = 1'b0;
        load          = 1'b0;
        load_status   = i_head.status;
        load_data     = 8'h00;
        load_cursor   = i_head.cursor[14:0];
        mem_we        = 1'b0;
        mem_waddr     = r_dst;
        mem_wdata     = r_rdata;
        mem_raddr     = r_src;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 8'h00;
                n_clr     = r_clr + 1'b1;
                if (r_clr == LAST_ADDR) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_q_flags.empty && out_free) begin
                    o_pop         = 1'b1;
                    n_hold_status = i_head.status;
                    n_hold_cursor = i_head.cursor[14:0];
                    unique case (i_head.kind)
                        CMD_NONE: begin
                            load = 1'b1;
                        end
                        CMD_WRITE: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_head.dst[AW-1:0];
                            mem_wdata = i_head.data;
                            load      = 1'b1;
                        end
                        CMD_READ: begin
                            mem_raddr = i_head.src[AW-1:0];
                            n_state   = BK_READ;
                        end
                        CMD_COPY: begin
                            n_src   = i_head.src[AW-1:0];
                            n_dst   = i_head.dst[AW-1:0];
                            n_cnt   = i_head.count;
                            n_state = BK_COPY_RD;
                        end
                    endcase
                end
            end
            BK_READ: begin
                load        = 1'b1;
                load_status = r_hold_status;
                load_data   = r_rdata;
                load_cursor = r_hold_cursor;
                n_state     = BK_IDLE;
            end
            BK_COPY_RD: begin
                n_state = BK_COPY_WR;
            end
            BK_COPY_WR: begin
                mem_we = 1'b1;
                n_src  = r_src + 1'b1;
                n_dst  = r_dst + 1'b1;
                n_cnt  = r_cnt - 15'd1;
                if (r_cnt <= 15'd1) begin
                    load        = 1'b1;
                    load_status = r_hold_status;
                    load_cursor = r_hold_cursor;
                    n_state     = BK_IDLE;
                end else begin
                    n_state = BK_COPY_RD;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid  = r_out_valid & ~o_chan.ready;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_cursor = r_out_cursor;
        if (load) begin
            n_out_valid  = 1'b1;
            n_out_status = load_status;
            n_out_data   = load_data;
            n_out_cursor = load_cursor;
        end
    end

    assign o_clear_done           = (r_state != BK_CLEAR);
    assign o_chan.valid           = r_out_valid;
    assign o_chan.status          = r_out_status;
    assign o_chan.read_data       = r_out_data;
    assign o_chan.cursor_position = r_out_cursor;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the delta frame stream decoder with its own decoding predictor.
module tb_top;
    import dfsd_pkg::*;

    localparam int FRAME_BYTES = 32768;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int NEAR_BANK_END = 40;
    localparam int FAR_GUARD = 48;
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        t_status     status;
        logic [7:0]  data;
        logic [14:0] cursor;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    dfsd_in_if  in_chan ();
    dfsd_out_if out_chan ();

    delta_frame_stream_decoder_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_chan    (in_chan),
        .o_out_chan   (out_chan)
    );

    logic [7:0]  mirror_buf [FRAME_BYTES];
    logic [14:0] mirror_cursor;
    t_phase      mirror_phase;
    logic [15:0] mirror_word;
    int          mirror_left;
    logic [15:0] mirror_dict;
    logic [15:0] mirror_spos;

    t_outcome pending_results[$];
    int       items_sent;
    int       mismatches;
    int       cycle_count;
    int       send_gap_pct;
    int       recv_stall_pct;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int run_bytes(input logic [15:0] w);
        return int'(w[14:1]) + 1;
    endfunction

    function automatic t_outcome decode_item(input logic op, input logic [7:0] b,
                                             input logic [14:0] addr);
        t_outcome    r;
        logic [15:0] pos;
        logic [15:0] src;
        logic [14:0] rd_ptr;
        r.status = ST_TAKEN;
        r.data = 8'h00;
        if (op == OP_READ) begin
            r.status = ST_READ_DONE;
            r.data = mirror_buf[addr];
        end else begin
            pos = mirror_spos;
            mirror_spos = mirror_spos + 16'd1;
            case (mirror_phase)
                PH_LOW: begin
                    mirror_word = {8'h00, b};
                    mirror_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    mirror_word = {b, mirror_word[7:0]};
                    if (mirror_word[15]) begin
                        if (mirror_word[0]) begin
                            mirror_cursor = mirror_cursor + 15'(run_bytes(mirror_word));
                            mirror_phase = PH_LOW;
                        end else begin
                            mirror_phase = PH_DICT_LOW;
                        end
                    end else if (mirror_word[0]) begin
                        mirror_left = run_bytes(mirror_word);
                        mirror_phase = PH_LITERAL;
                    end else begin
                        case (t_ctl_sel'(mirror_word[2:1]))
                            SEL_BANK_SKIP: begin
                                if (pos == 16'd0) begin
                                    mirror_word = {8'h00, b};
                                    mirror_phase = PH_HIGH;
                                end else if (mirror_spos == 16'd0) begin
                                    mirror_phase = PH_LOW;
                                end else begin
                                    mirror_phase = PH_BANK_SKIP;
                                end
                            end
                            SEL_END_FRAME: begin
                                mirror_cursor = 15'd0;
                                mirror_phase = PH_LOW;
                                r.status = ST_END_FRAME;
                            end
                            SEL_END_ANIM: begin
                                mirror_cursor = 15'd0;
                                mirror_phase = PH_LOW;
                                r.status = ST_END_ANIM;
                            end
                            default: begin
                                mirror_cursor = 15'd0;
                                mirror_phase = PH_LOW;
                                r.status = ST_RESERVED;
                            end
                        endcase
                    end
                end
                PH_LITERAL: begin
                    mirror_buf[mirror_cursor] = b;
                    mirror_cursor = mirror_cursor + 15'd1;
                    if (mirror_left > 0) mirror_left--;
                    if (mirror_left == 0) mirror_phase = PH_LOW;
                end
                PH_DICT_LOW: begin
                    mirror_dict = {8'h00, b};
                    mirror_phase = PH_DICT_HIGH;
                end
                PH_DICT_HIGH: begin
                    mirror_dict = {b, mirror_dict[7:0]};
                    src = mirror_dict - DICT_BIAS;
                    rd_ptr = src[14:0];
                    repeat (run_bytes(mirror_word)) begin
                        mirror_buf[mirror_cursor] = mirror_buf[rd_ptr];
                        mirror_cursor = mirror_cursor + 15'd1;
                        rd_ptr = rd_ptr + 15'd1;
                    end
                    mirror_phase = PH_LOW;
                end
                PH_BANK_SKIP: begin
                    if (mirror_spos == 16'd0) mirror_phase = PH_LOW;
                end
                default: begin
                    mirror_phase = PH_LOW;
                end
            endcase
        end
        r.cursor = mirror_cursor;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: status %0d data %02h cursor %04h",
                             out_chan.status, out_chan.read_data, out_chan.cursor_position);
            end else begin
                want = pending_results.pop_front();
                if (out_chan.status !== want.status || out_chan.read_data !== want.data ||
                    out_chan.cursor_position !== want.cursor) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected %0d/%02h/%04h got %0d/%02h/%04h",
                                 want.status, want.data, want.cursor, out_chan.status,
                                 out_chan.read_data, out_chan.cursor_position);
                end
            end
        end
        out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_item(input logic op, input logic [7:0] b, input logic [14:0] addr);
        while ($urandom_range(99) < send_gap_pct) begin
            in_chan.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.opcode <= op;
        in_chan.stream_byte <= b;
        in_chan.read_address <= addr;
        @(posedge i_clk);
        while (in_chan.ready !== 1'b1) @(posedge i_clk);
        pending_results.insert(pending_results.size(), decode_item(op, b, addr));
        items_sent++;
    endtask

    task automatic feed(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (mirror_phase == PH_HIGH && mirror_spos != 16'd0 && !mirror_word[0] &&
            mirror_word[2:1] == SEL_BANK_SKIP && !v[7] &&
            int'(16'hFFFF - mirror_spos) > FAR_GUARD)
            v[7] = 1'b1;
        send_item(OP_FEED, v, 15'($urandom));
    endtask

    task automatic read_at(input logic [14:0] a);
        send_item(OP_READ, 8'($urandom), a);
    endtask

    task automatic feed_word(input logic [15:0] w);
        feed(w[7:0]);
        if ($urandom_range(11) == 0) read_at(15'($urandom));
        feed(w[15:8]);
    endtask

    task automatic put_literal(input int n);
        feed_word({1'b0, 14'(n - 1), 1'b1});
        repeat (n) begin
            if ($urandom_range(9) == 0) read_at(mirror_cursor - 15'($urandom_range(1, 32)));
            feed(8'($urandom));
        end
    endtask

    task automatic put_skip(input int n);
        feed_word({1'b1, 14'(n - 1), 1'b1});
    endtask

    task automatic put_copy(input int n, input logic [15:0] src_word);
        feed_word({1'b1, 14'(n - 1), 1'b0});
        feed_word(src_word);
    endtask

    task automatic put_control(input t_ctl_sel sel);
        feed_word({1'b0, 12'($urandom), sel, 1'b0});
    endtask

    task automatic put_bank_skip();
        put_control(SEL_BANK_SKIP);
        while (mirror_phase == PH_BANK_SKIP) feed(8'($urandom));
    endtask

    task automatic set_stream_offset(input logic [15:0] v);
        in_chan.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        mirror_spos = v;
    endtask

    task automatic test_cleared_buffer();
        read_at(15'd0);
        read_at(15'h7FFF);
    endtask

    task automatic test_literal_skip_copy();
        set_stream_offset(16'h0000);
        feed_word({1'b0, 14'd1, 1'b1});
        feed(8'h00);
        read_at(15'd0);
        feed(8'hFF);
        put_copy(6, DICT_BIAS + 16'(mirror_cursor) - 16'd2);
        read_at(15'd5);
        put_skip(16384);
        put_skip(1);
        put_copy(16384, 16'hFFFF);
        put_copy(1, 16'h0000);
    endtask

    task automatic test_frame_ends();
        feed({5'($urandom), SEL_END_FRAME, 1'b0});
        read_at(15'h7FFF);
        feed(8'h7F);
        put_control(SEL_END_ANIM);
        put_control(SEL_RESERVED);
    endtask

    task automatic test_bank_skips();
        set_stream_offset(16'hFFFA);
        put_bank_skip();
        set_stream_offset(16'hFFFE);
        put_bank_skip();
        set_stream_offset(16'hFFFF);
        feed(8'h00);
        feed(8'h03);
        feed(8'h80);
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [15:0] offset, input int count);
        int stop_at;
        int pick;
        int len;
        set_stream_offset(offset);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (mirror_phase == PH_LOW && int'(16'hFFFF - mirror_spos) <= NEAR_BANK_END &&
                $urandom_range(2) == 0) begin
                put_bank_skip();
            end else if (pick < 8) begin
                read_at(15'($urandom));
            end else if (pick < 14) begin
                read_at(mirror_cursor - 15'($urandom_range(1, 40)));
            end else if (pick < 22) begin
                feed(8'($urandom));
            end else if (pick < 52) begin
                len = ($urandom_range(15) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
                put_literal(len);
            end else if (pick < 72) begin
                len = ($urandom_range(24) == 0) ? $urandom_range(1, 400) : $urandom_range(1, 20);
                if ($urandom_range(1) == 0)
                    put_copy(len, DICT_BIAS + 16'(mirror_cursor) - 16'($urandom_range(1, 40)));
                else
                    put_copy(len, 16'($urandom));
            end else if (pick < 88) begin
                put_skip(($urandom_range(3) == 0) ? $urandom_range(1, 16384)
                                                  : $urandom_range(1, 64));
            end else begin
                put_control(t_ctl_sel'($urandom_range(3, 1)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 16'h0000;
        in_chan.valid = 1'b0;
        in_chan.opcode = OP_FEED;
        in_chan.stream_byte = 8'h00;
        in_chan.read_address = 15'd0;
        out_chan.ready = 1'b0;
        items_sent = 0;
        mismatches = 0;
        cycle_count = 0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        foreach (mirror_buf[i]) mirror_buf[i] = 8'h00;
        mirror_cursor = 15'd0;
        mirror_phase = PH_LOW;
        mirror_word = 16'h0000;
        mirror_left = 0;
        mirror_dict = 16'h0000;
        mirror_spos = 16'h0000;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_buffer();
        test_literal_skip_copy();
        test_frame_ends();
        test_bank_skips();
        test_random_traffic(17, 53, 16'hFF80 + 16'($urandom_range(0, 96)), 620);
        test_random_traffic(53, 17, 16'($urandom), 620);
        test_random_traffic(0, 0, 16'hFFA0 + 16'($urandom_range(0, 64)), 620);

        in_chan.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
